### rtl/spi_brr_pkg.sv
// Shared types, register map and helpers for the SPI burst register reader.
package spi_brr_pkg;

  localparam int unsigned AddrWidth = 4;

  typedef enum logic [1:0] {
    RegReadFlag   = 2'd0,
    RegAutoincFlag = 2'd1,
    RegHalfPeriod = 2'd2,
    RegGap        = 2'd3
  } reg_idx_e;

  localparam logic [15:0] ReadFlagReset   = 16'h8000;
  localparam logic [15:0] AutoincFlagReset = 16'h1000;
  localparam logic [7:0]  HalfPeriodReset = 8'd10;
  localparam logic [7:0]  GapReset        = 8'd20;

  typedef struct packed {
    logic        action;
    logic [15:0] reg_address;
    logic [6:0]  word_count;
    logic        miso_level;
  } spi_brr_in_t;

  typedef struct packed {
    logic        cs_n;
    logic        sclk;
    logic        mosi;
    logic        busy_res;
    logic        word_valid;
    logic [15:0] read_word;
    logic        last_word;
    logic        start_rejected;
  } spi_brr_out_t;

  typedef struct packed {
    logic [15:0] read_flag_mask;
    logic [15:0] autoinc_flag_mask;
    logic [7:0]  half_period_ticks;
    logic [7:0]  gap_ticks;
  } spi_brr_cfg_t;

  function automatic logic [7:0] span(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

endpackage

### rtl/spi_burst_register_reader_unit.sv
// Top level of the SPI burst register reader with its register port and result register.
// The result beat for an input beat is registered and appears on the output in the next cycle.
// Throughput: one beat per cycle while the single output register is empty or being taken.
// Each input beat is one tick of the serial timing; the sequencer state advances per beat.
// Reset clears the sequencer, the output valid flag and loads the register defaults.
module spi_burst_register_reader_unit import spi_brr_pkg::*; #(
  parameter int unsigned MaxBurst = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  spi_brr_in_t          in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output spi_brr_out_t         out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  spi_brr_cfg_t cfg_q;
  spi_brr_out_t res;
  spi_brr_out_t out_q;
  logic         out_valid_q;
  logic         accept;
  reg_idx_e     reg_idx;

  assign pready     = 1'b1;
  assign reg_idx    = reg_idx_e'(paddr[AddrWidth-1:2]);
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.read_flag_mask    <= ReadFlagReset;
      cfg_q.autoinc_flag_mask <= AutoincFlagReset;
      cfg_q.half_period_ticks <= HalfPeriodReset;
      cfg_q.gap_ticks         <= GapReset;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        RegReadFlag:    cfg_q.read_flag_mask    <= pwdata[15:0];
        RegAutoincFlag: cfg_q.autoinc_flag_mask <= pwdata[15:0];
        RegHalfPeriod:  cfg_q.half_period_ticks <= pwdata[7:0];
        RegGap:         cfg_q.gap_ticks         <= pwdata[7:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegReadFlag:    prdata = {16'd0, cfg_q.read_flag_mask};
      RegAutoincFlag: prdata = {16'd0, cfg_q.autoinc_flag_mask};
      RegHalfPeriod:  prdata = {24'd0, cfg_q.half_period_ticks};
      RegGap:         prdata = {24'd0, cfg_q.gap_ticks};
      default:        prdata = 32'd0;
    endcase
  end

  spi_brr_core #(
    .MaxBurst(MaxBurst)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (accept),
    .item_i (in_data_i),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_word_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.word_valid |-> out_q.busy_res && !out_q.cs_n)
    else $error("word reported outside a transfer");

  a_last_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.last_word |-> out_q.word_valid)
    else $error("last mark without a word");

  a_cs_matches_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.cs_n != out_q.busy_res)
    else $error("chip select disagrees with busy");

  a_empty_takes_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty output register");

endmodule

### rtl/spi_brr_core.sv
// Transfer sequencer that advances the SPI timing by one tick per accepted beat.
module spi_brr_core import spi_brr_pkg::*; #(
  parameter int unsigned MaxBurst = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  spi_brr_in_t  item_i,
  input  spi_brr_cfg_t cfg_i,
  output spi_brr_out_t res_o
);

  typedef enum logic [5:0] {
    PhIdle = 6'b000001,
    PhLead = 6'b000010,
    PhCmd  = 6'b000100,
    PhMid  = 6'b001000,
    PhData = 6'b010000,
    PhTail = 6'b100000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  tick_q, tick_d;
  logic [4:0]  bit_q, bit_d;
  logic [15:0] cmd_q, cmd_d;
  logic [15:0] data_q, data_d;
  logic [6:0]  words_q, words_d;
  logic        clk_lvl_q, clk_lvl_d;

  logic        running;
  logic [7:0]  tick_dec;
  logic [4:0]  bit_inc;
  logic [6:0]  words_dec;
  logic        count_bad;

  assign tick_dec  = tick_q - 8'd1;
  assign bit_inc   = bit_q + 5'd1;
  assign words_dec = (words_q == 7'd0) ? 7'd0 : words_q - 7'd1;
  assign count_bad = (item_i.word_count == 7'd0) ||
                     (32'(item_i.word_count) > 32'(MaxBurst));

  always_comb begin
    case (phase_q)
      PhLead, PhCmd, PhMid, PhData, PhTail: running = 1'b1;
      default:                              running = 1'b0;
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    tick_d    = tick_q;
    bit_d     = bit_q;
    cmd_d     = cmd_q;
    data_d    = data_q;
    words_d   = words_q;
    clk_lvl_d = clk_lvl_q;
    res_o     = '0;

    if (!running) begin
      phase_d = PhIdle;
      if (item_i.action) begin
        if (count_bad) begin
          res_o.start_rejected = 1'b1;
        end else begin
          cmd_d = item_i.reg_address | cfg_i.read_flag_mask |
                  ((item_i.word_count > 7'd1) ? cfg_i.autoinc_flag_mask : 16'd0);
          words_d   = item_i.word_count;
          bit_d     = 5'd0;
          data_d    = 16'd0;
          clk_lvl_d = 1'b0;
          tick_d    = span(cfg_i.gap_ticks);
          phase_d   = PhLead;
        end
      end
    end else begin
      res_o.start_rejected = item_i.action;
      tick_d = tick_dec;
      if (tick_dec == 8'd0) begin
        case (phase_q)
          PhLead: begin
            phase_d   = PhCmd;
            bit_d     = 5'd0;
            clk_lvl_d = 1'b0;
            tick_d    = span(cfg_i.half_period_ticks);
          end
          PhCmd: begin
            if (!clk_lvl_q) begin
              clk_lvl_d = 1'b1;
              tick_d    = span(cfg_i.half_period_ticks);
            end else begin
              clk_lvl_d = 1'b0;
              bit_d     = bit_inc;
              if (bit_inc >= 5'd16) begin
                phase_d = PhMid;
                tick_d  = span(cfg_i.gap_ticks);
              end else begin
                cmd_d  = {cmd_q[14:0], 1'b0};
                tick_d = span(cfg_i.half_period_ticks);
              end
            end
          end
          PhMid: begin
            phase_d   = PhData;
            bit_d     = 5'd0;
            data_d    = 16'd0;
            clk_lvl_d = 1'b0;
            tick_d    = span(cfg_i.half_period_ticks);
          end
          PhData: begin
            if (!clk_lvl_q) begin
              clk_lvl_d = 1'b1;
              data_d    = {data_q[14:0], item_i.miso_level};
              tick_d    = span(cfg_i.half_period_ticks);
            end else begin
              clk_lvl_d = 1'b0;
              bit_d     = bit_inc;
              tick_d    = span(cfg_i.half_period_ticks);
              if (bit_inc >= 5'd16) begin
                res_o.word_valid = 1'b1;
                res_o.read_word  = data_q;
                res_o.last_word  = (words_q <= 7'd1);
                words_d          = words_dec;
                bit_d            = 5'd0;
                data_d           = 16'd0;
                if (words_dec == 7'd0) begin
                  phase_d = PhTail;
                  tick_d  = span(cfg_i.gap_ticks);
                end
              end
            end
          end
          default: begin
            phase_d   = PhIdle;
            clk_lvl_d = 1'b0;
            tick_d    = 8'd0;
          end
        endcase
      end
    end

    res_o.cs_n     = (phase_d == PhIdle);
    res_o.busy_res = (phase_d != PhIdle);
    res_o.sclk     = clk_lvl_d;
    res_o.mosi     = cmd_d[15];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      tick_q    <= 8'd0;
      bit_q     <= 5'd0;
      cmd_q     <= 16'd0;
      data_q    <= 16'd0;
      words_q   <= 7'd0;
      clk_lvl_q <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      tick_q    <= tick_d;
      bit_q     <= bit_d;
      cmd_q     <= cmd_d;
      data_q    <= data_d;
      words_q   <= words_d;
      clk_lvl_q <= clk_lvl_d;
    end
  end

endmodule
